[hdl/gasa_pkg.sv]
// Shared constants and controller/datapath interface types for the glyph atlas allocator.
`default_nettype none

package gasa_pkg;

  localparam int ATLAS_DIM_DEFAULT  = 512;
  localparam int RING_SLOTS_DEFAULT = 512;
  localparam int GLYPH_DIM_W        = 8;
  localparam int OUT_W              = 9;

  typedef struct packed {
    logic load;
    logic place_x;
    logic place_y;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic band;
    logic walk_more;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hdl/glyph_atlas_shelf_allocator.sv]
// Top level of the glyph atlas shelf allocator: controller plus datapath.
//
// Usage: a glyph request item enters on the in_valid/in_ready channel with
// already_cached, glyph_width and glyph_height. Exactly one result item leaves
// on the out_valid/out_ready channel for every request, in order.
// A request is worked on alone. After acceptance, a hit goes through S_PLACE_X
// and S_FINAL to the result register, a placement without row band growth goes
// through S_PLACE_X, S_PLACE_Y and S_FINAL, and a placement that grows the row
// band adds S_WALK, which evicts slots in the band walk; that walk reads one
// stored slot top per cycle from the slot memory. A wrap to the top evicts all
// pending slots at once from the ring pointers. The result is visible right
// after it is written; the next request can be taken in the following cycle.
// A finished result waits in the output register while the next request is
// already worked on; if the receiver still stalls when that request is done,
// the block holds it and takes no new request until the output frees up.
// Reset empties the slot ring, clears the cursor and drops any waiting result;
// the slot memory needs no clearing pass, as only written slots are ever read.
`default_nettype none

module glyph_atlas_shelf_allocator #(
  parameter int ATLAS_DIM  = gasa_pkg::ATLAS_DIM_DEFAULT,
  parameter int RING_SLOTS = gasa_pkg::RING_SLOTS_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              already_cached,
  input  wire  [gasa_pkg::GLYPH_DIM_W-1:0] glyph_width,
  input  wire  [gasa_pkg::GLYPH_DIM_W-1:0] glyph_height,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             accepted,
  output logic [gasa_pkg::OUT_W-1:0]       slot_id,
  output logic [gasa_pkg::OUT_W-1:0]       glyph_x,
  output logic [gasa_pkg::OUT_W-1:0]       glyph_y,
  output logic [gasa_pkg::OUT_W-1:0]       evict_first,
  output logic [gasa_pkg::OUT_W-1:0]       evict_count
);

  gasa_pkg::cmd_t    cmd;
  gasa_pkg::status_t st;

  gasa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  gasa_datapath #(
    .ATLAS_DIM  (ATLAS_DIM),
    .RING_SLOTS (RING_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .already_cached (already_cached),
    .glyph_width    (glyph_width),
    .glyph_height   (glyph_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .accepted       (accepted),
    .slot_id        (slot_id),
    .glyph_x        (glyph_x),
    .glyph_y        (glyph_y),
    .evict_first    (evict_first),
    .evict_count    (evict_count)
  );

endmodule

`default_nettype wire

[hdl/gasa_ctrl.sv]
// Sequencing state machine for the glyph atlas allocator.
`default_nettype none

module gasa_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  gasa_pkg::status_t st,
  output gasa_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLACE_X,
    S_PLACE_Y,
    S_WALK,
    S_FINAL
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.load    = (state == S_IDLE) && in_valid;
    cmd.place_x = (state == S_PLACE_X) && !st.hit;
    cmd.place_y = (state == S_PLACE_Y);
    cmd.step    = (state == S_WALK) && st.walk_more;
    cmd.finish  = (state == S_FINAL) && st.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_PLACE_X;
        end
        S_PLACE_X: begin
          state <= st.hit ? S_FINAL : S_PLACE_Y;
        end
        S_PLACE_Y: begin
          state <= st.band ? S_WALK : S_FINAL;
        end
        S_WALK: begin
          if (!st.walk_more) state <= S_FINAL;
        end
        S_FINAL: begin
          if (st.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/gasa_datapath.sv]
// Placement cursor, slot ring, slot-top memory and result register of the allocator.
`default_nettype none

module gasa_datapath #(
  parameter int ATLAS_DIM  = gasa_pkg::ATLAS_DIM_DEFAULT,
  parameter int RING_SLOTS = gasa_pkg::RING_SLOTS_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst,
  input  gasa_pkg::cmd_t                     cmd,
  output gasa_pkg::status_t                  st,
  input  wire                                already_cached,
  input  wire  [gasa_pkg::GLYPH_DIM_W-1:0]   glyph_width,
  input  wire  [gasa_pkg::GLYPH_DIM_W-1:0]   glyph_height,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               accepted,
  output logic [gasa_pkg::OUT_W-1:0]         slot_id,
  output logic [gasa_pkg::OUT_W-1:0]         glyph_x,
  output logic [gasa_pkg::OUT_W-1:0]         glyph_y,
  output logic [gasa_pkg::OUT_W-1:0]         evict_first,
  output logic [gasa_pkg::OUT_W-1:0]         evict_count
);

  localparam int CW = $clog2(ATLAS_DIM + 520);
  localparam int PW = $clog2(RING_SLOTS);
  localparam int NW = $clog2(RING_SLOTS + 1);
  localparam int OW = gasa_pkg::OUT_W;
  localparam logic [CW-1:0] ATLAS = CW'(ATLAS_DIM);
  localparam logic [CW-1:0] PAD   = CW'(2);
  localparam logic [PW-1:0] LAST  = PW'(RING_SLOTS - 1);
  localparam logic [NW:0]   RINGN = (NW + 1)'(RING_SLOTS);

  function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  logic [CW-1:0] cx, cy, rh;
  logic [PW-1:0] oldest, nxt, rd, first;
  logic [NW-1:0] cnt;
  logic [CW-1:0] band_lo, band_hi;
  logic [gasa_pkg::GLYPH_DIM_W-1:0] w_q, h_q;
  logic          hit_q;
  logic [CW-1:0] mem [RING_SLOTS];
  logic [CW-1:0] mem_q;

  logic [CW-1:0] w_ext, h2;
  logic          xwrap, ywrap, band_n, full;
  logic [CW-1:0] cy2, rh2;
  logic [NW:0]   dist_full;
  logic [PW-1:0] rd_next, rd_f;
  logic [NW-1:0] cnt_f;

  always_comb begin
    w_ext     = CW'(w_q);
    h2        = CW'(h_q) + PAD;
    xwrap     = (w_ext + cx + PAD) > ATLAS;
    ywrap     = (h2 + cy) >= ATLAS;
    cy2       = ywrap ? '0 : cy;
    rh2       = ywrap ? '0 : rh;
    band_n    = h2 >= rh2;
    dist_full = (NW + 1)'(nxt) + ((nxt >= rd) ? '0 : RINGN) - (NW + 1)'(rd);
    full      = (ring_inc(nxt) == rd);
    rd_f      = full ? ring_inc(rd) : rd;
    cnt_f     = cnt + NW'(full);
  end

  always_comb begin
    priority if (cmd.load) begin
      rd_next = oldest;
    end else if (cmd.place_y && ywrap) begin
      rd_next = nxt;
    end else if (cmd.step) begin
      rd_next = ring_inc(rd);
    end else if (cmd.finish && !hit_q) begin
      rd_next = rd_f;
    end else begin
      rd_next = rd;
    end
  end

  always_comb begin
    st.hit       = hit_q;
    st.band      = band_n;
    st.walk_more = (rd != nxt) && (mem_q >= band_lo) && (mem_q < band_hi);
    st.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_next];
    if (cmd.finish && !hit_q) begin
      mem[nxt] <= cy + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd <= rd_next;
    if (cmd.load) begin
      hit_q <= already_cached;
      w_q   <= glyph_width;
      h_q   <= glyph_height;
      first <= oldest;
      cnt   <= '0;
    end
    if (cmd.place_y) begin
      band_lo <= rh2 + cy2;
      band_hi <= h2 + cy2;
      if (ywrap) cnt <= dist_full[NW-1:0];
    end
    if (cmd.step) begin
      cnt <= cnt + NW'(1);
    end
    if (cmd.finish) begin
      if (hit_q) begin
        accepted    <= 1'b0;
        slot_id     <= '0;
        glyph_x     <= '0;
        glyph_y     <= '0;
        evict_first <= '0;
        evict_count <= '0;
      end else begin
        accepted    <= 1'b1;
        slot_id     <= OW'(nxt);
        glyph_x     <= OW'(cx + CW'(1));
        glyph_y     <= OW'(cy + CW'(1));
        evict_first <= (cnt_f != '0) ? OW'(first) : '0;
        evict_count <= OW'(cnt_f);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx        <= '0;
      cy        <= '0;
      rh        <= '0;
      oldest    <= '0;
      nxt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.place_x && xwrap) begin
        cx <= '0;
        cy <= cy + rh;
        rh <= '0;
      end
      if (cmd.place_y) begin
        if (ywrap) begin
          cx <= '0;
        end
        cy <= cy2;
        rh <= band_n ? h2 : rh2;
      end
      if (cmd.finish && !hit_q) begin
        oldest <= rd_f;
        cx     <= cx + w_ext + PAD;
        nxt    <= ring_inc(nxt);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
